[hw/rtl/ccens_pkg.sv]
// Shared constants, command type and kernel helper for the CENS post-processor.
`default_nettype none

package ccens_pkg;

    localparam int CHROMA_BINS_DEF = 12;
    localparam int SMOOTH_LEN_DEF  = 41;
    localparam int MAG_BITS_DEF    = 24;

    localparam int MAG_W       = 24;
    localparam int VALUE_W     = 16;
    localparam int BIN_W       = 4;
    localparam int KERN_W      = 17;
    localparam int QUANT_W     = 3;
    localparam int MAX_BINS    = 12;
    localparam int ROW_W       = MAX_BINS * QUANT_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // Full scale of a Q1.15 output value
    localparam logic [16:0] VALUE_MAX = 17'd32768;

    typedef struct packed {
        logic             is_flush;
        logic             smooth;
        logic [ROW_W-1:0] quant;
    } cmd_t;

    // Q30 sine by Taylor series, nested form; used for the kernel table only
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        return (x * t) >> 30;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/chroma_cens_postprocess.sv]
// Top level of the CENS chroma post-processor.
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ------------------------
//  input     s_op, s_magnitude                   s_valid / s_ready
//  result    m_value, m_bin_index, m_last,       m_valid / m_ready
//            m_clip_done
//  config    cfg_wdata (smoothing on)            cfg_we, no wait
//
// The item that completes a frame is quantized in the front end, one bin per cycle.
// An emitted frame passes through tap accumulation (one history row per memory
// read), squares, scaling, the square root and the divides.
// Sync active-low reset; the history clears at once through per-row valid bits.
// A two-entry command queue lets the front keep collecting while results stall.
`default_nettype none

module chroma_cens_postprocess #(
    parameter int CHROMA_BINS = ccens_pkg::CHROMA_BINS_DEF,
    parameter int SMOOTH_LEN  = ccens_pkg::SMOOTH_LEN_DEF,
    parameter int MAG_BITS    = ccens_pkg::MAG_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_op,
    input  wire logic [ccens_pkg::MAG_W-1:0]   s_magnitude,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ccens_pkg::VALUE_W-1:0]      m_value,
    output logic [ccens_pkg::BIN_W-1:0]        m_bin_index,
    output logic                               m_last,
    output logic                               m_clip_done
);
    import ccens_pkg::*;

    cmd_t front_cmd, back_cmd;
    logic q_push, q_full, q_pop, q_not_empty;

    ccens_front #(
        .CHROMA_BINS(CHROMA_BINS),
        .MAG_BITS   (MAG_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_magnitude(s_magnitude),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (front_cmd)
    );

    ccens_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (back_cmd),
        .not_empty(q_not_empty)
    );

    ccens_back #(
        .CHROMA_BINS(CHROMA_BINS),
        .SMOOTH_LEN (SMOOTH_LEN)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (q_not_empty),
        .cmd_data   (back_cmd),
        .cmd_pop    (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value    (m_value),
        .m_bin_index(m_bin_index),
        .m_last     (m_last),
        .m_clip_done(m_clip_done)
    );

endmodule

`default_nettype wire

[hw/rtl/ccens_front.sv]
// Front end: collects bins, sums the frame, quantizes and issues commands.
`default_nettype none

module ccens_front #(
    parameter int CHROMA_BINS = ccens_pkg::CHROMA_BINS_DEF,
    parameter int MAG_BITS    = ccens_pkg::MAG_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_op,
    input  wire logic [ccens_pkg::MAG_W-1:0] s_magnitude,
    input  wire logic                        q_full,
    output logic                             q_push,
    output ccens_pkg::cmd_t                  q_data
);
    import ccens_pkg::*;

    localparam int BIDX_W = $clog2(CHROMA_BINS);
    localparam int SUM_W  = MAG_BITS + $clog2(CHROMA_BINS);
    localparam int CMP_W  = MAG_BITS + 6;
    localparam logic [BIDX_W-1:0] LAST_BIN = BIDX_W'(CHROMA_BINS - 1);

    typedef enum logic [1:0] {FS_COLLECT, FS_QUANT, FS_ISSUE} fstate_t;

    fstate_t             state_reg;
    logic [BIDX_W-1:0]   bin_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [MAG_BITS-1:0] collect_reg [CHROMA_BINS];
    logic [ROW_W-1:0]    row_reg;
    logic                smooth_reg;

    logic                accept;
    logic [MAG_BITS-1:0] mag_in;
    logic [CMP_W-1:0]    v5, v10, v20, s1, s2;
    logic [QUANT_W-1:0]  quant_next;

    assign s_ready = (state_reg == FS_COLLECT) && !q_full;
    assign accept  = s_valid && s_ready;
    assign mag_in  = MAG_BITS'({8'd0, s_magnitude});

    assign q_push = ((state_reg == FS_ISSUE) && !q_full) || (accept && (s_op == OP_FLUSH));
    assign q_data = '{is_flush: (state_reg != FS_ISSUE), smooth: smooth_reg, quant: row_reg};

    // threshold tests without division: 5v>2s, 5v>s, 10v>s, 20v>s
    always_comb begin
        v5  = CMP_W'(collect_reg[bin_reg]) * CMP_W'(5);
        v10 = v5 << 1;
        v20 = v5 << 2;
        s1  = CMP_W'(sum_reg);
        s2  = s1 << 1;
        quant_next = QUANT_W'(v5 > s2) + QUANT_W'(v5 > s1) + QUANT_W'(v10 > s1)
                   + QUANT_W'(v20 > s1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= FS_COLLECT;
            bin_reg    <= '0;
            sum_reg    <= '0;
            smooth_reg <= 1'b1;
        end else begin
            if (cfg_we) begin
                smooth_reg <= cfg_wdata;
            end
            case (state_reg)
                FS_COLLECT: begin
                    if (accept) begin
                        if (s_op == OP_FLUSH) begin
                            bin_reg <= '0;
                            sum_reg <= '0;
                        end else begin
                            collect_reg[bin_reg] <= mag_in;
                            sum_reg <= sum_reg + SUM_W'(mag_in);
                            if (bin_reg == LAST_BIN) begin
                                bin_reg   <= '0;
                                state_reg <= FS_QUANT;
                            end else begin
                                bin_reg <= bin_reg + 1'b1;
                            end
                        end
                    end
                end
                FS_QUANT: begin
                    row_reg[bin_reg*QUANT_W +: QUANT_W] <= quant_next;
                    if (bin_reg == LAST_BIN) begin
                        bin_reg   <= '0;
                        state_reg <= FS_ISSUE;
                    end else begin
                        bin_reg <= bin_reg + 1'b1;
                    end
                end
                FS_ISSUE: begin
                    if (!q_full) begin
                        sum_reg   <= '0;
                        state_reg <= FS_COLLECT;
                    end
                end
                default: state_reg <= FS_COLLECT;
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ccens_queue.sv]
// Small command FIFO between the front end and the back end.
`default_nettype none

module ccens_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  ccens_pkg::cmd_t      push_data,
    output logic                 full,
    input  wire logic            pop,
    output ccens_pkg::cmd_t      pop_data,
    output logic                 not_empty
);
    import ccens_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                entry_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ccens_back.sv]
// Back end: history, Hann smoothing, L2 norm (sqrt and divide) and result output.
`default_nettype none

module ccens_back #(
    parameter int CHROMA_BINS = ccens_pkg::CHROMA_BINS_DEF,
    parameter int SMOOTH_LEN  = ccens_pkg::SMOOTH_LEN_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cmd_valid,
    input  ccens_pkg::cmd_t                    cmd_data,
    output logic                               cmd_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ccens_pkg::VALUE_W-1:0]      m_value,
    output logic [ccens_pkg::BIN_W-1:0]        m_bin_index,
    output logic                               m_last,
    output logic                               m_clip_done
);
    import ccens_pkg::*;

    localparam int KLEN   = SMOOTH_LEN + 2;
    localparam int KHALF  = (KLEN - 1) / 2;
    localparam int DELAY  = SMOOTH_LEN / 2;
    localparam int HEAD_W = $clog2(SMOOTH_LEN);
    localparam int PEND_W = $clog2(DELAY + 1);
    localparam int KI_W   = $clog2(KLEN);
    localparam int BIDX_W = $clog2(CHROMA_BINS);
    localparam int HROW_W = CHROMA_BINS * QUANT_W;
    localparam int ACC_W  = KERN_W + QUANT_W + $clog2(SMOOTH_LEN + 1);
    localparam int SQ_W   = 2 * ACC_W;
    localparam int DIV_W  = 50;
    localparam int QUO_W  = 17;

    localparam logic [HEAD_W-1:0] LAST_ROW = HEAD_W'(SMOOTH_LEN - 1);
    localparam logic [BIDX_W-1:0] LAST_BIN = BIDX_W'(CHROMA_BINS - 1);
    localparam logic [PEND_W-1:0] DELAY_P  = PEND_W'(DELAY);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ACC, ST_ACC_END, ST_SQ, ST_SQ_END,
        ST_NORM, ST_SQRT, ST_DIV_INIT, ST_DIV, ST_OUT
    } bstate_t;

    // Hann kernel, evaluated at elaboration
    logic [KERN_W-1:0] kern_tab [KLEN];
    for (genvar g = 0; g < KLEN; g++) begin : g_kern
        localparam int          M  = (g <= KLEN - 1 - g) ? g : KLEN - 1 - g;
        localparam logic [63:0] KX = (PI_Q30 * 64'(M)) / 64'(KLEN - 1);
        localparam logic [63:0] KS = sin_q30(KX);
        localparam logic [63:0] KW = (KS * KS + (64'd1 << 43)) >> 44;
        assign kern_tab[g] = KERN_W'(KW);
    end

    bstate_t             state_reg;
    logic [HROW_W-1:0]   hist_mem [SMOOTH_LEN];
    logic [HROW_W-1:0]   rd_data_reg;
    logic [SMOOTH_LEN-1:0] hist_valid_reg;
    logic [HEAD_W-1:0]   head_reg;
    logic [PEND_W-1:0]   pending_reg;
    logic [HEAD_W-1:0]   ptr_reg;
    logic [HEAD_W-1:0]   src_reg;
    logic [KI_W-1:0]     ksum_reg;
    logic                p1_use_reg;
    logic [KERN_W-1:0]   p1_kern_reg;
    logic [ACC_W-1:0]    acc_reg [CHROMA_BINS];
    logic [SQ_W-1:0]     sq_reg;
    logic                sq_vld_reg;
    logic [63:0]         ssum_reg;
    logic [4:0]          sh_reg;
    logic [4:0]          it_reg;
    logic [63:0]         root_reg;
    logic                zero_reg;
    logic [BIDX_W-1:0]   bidx_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [4:0]          dbit_reg;
    logic                done_reg;
    logic                clear_after_reg;
    logic                m_valid_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    logic [BIN_W-1:0]    m_bin_index_reg;
    logic                m_last_reg;
    logic                m_clip_done_reg;

    logic                mem_we;
    logic [HEAD_W-1:0]   head_inc, head_dec, ptr_dec;
    logic [PEND_W-1:0]   pend_dec;
    logic                src_in_kernel;
    logic [KI_W-1:0]     k_idx;
    logic [63:0]         sqrt_bit, sqrt_trial;
    logic [63:0]         a_sh;
    logic [DIV_W-1:0]    dvs;
    logic                out_free;

    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;
    assign mem_we   = cmd_pop && !cmd_data.is_flush;
    assign head_inc = (head_reg == LAST_ROW) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_ROW : head_reg - 1'b1;
    assign ptr_dec  = (ptr_reg == '0) ? LAST_ROW : ptr_reg - 1'b1;
    assign pend_dec = pending_reg - 1'b1;

    // tap k = delay + KHALF - src, only taps with k >= 0 contribute
    assign src_in_kernel = (KI_W'(src_reg) <= ksum_reg);
    assign k_idx         = src_in_kernel ? ksum_reg - KI_W'(src_reg) : '0;

    assign sqrt_bit   = 64'd1 << (6'd62 - {it_reg, 1'b0});
    assign sqrt_trial = root_reg + sqrt_bit;
    assign a_sh       = 64'(acc_reg[bidx_reg]) << sh_reg;
    assign dvs        = DIV_W'(root_reg[32:0]) << dbit_reg;
    assign out_free   = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_bin_index = m_bin_index_reg;
    assign m_last      = m_last_reg;
    assign m_clip_done = m_clip_done_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[head_reg] <= cmd_data.quant[HROW_W-1:0];
        end
        rd_data_reg <= hist_mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            pending_reg    <= '0;
            hist_valid_reg <= '0;
            p1_use_reg     <= 1'b0;
            sq_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // in ST_OUT the output register is reloaded below
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            p1_use_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
            if (p1_use_reg) begin
                for (int b = 0; b < CHROMA_BINS; b++) begin
                    acc_reg[b] <= acc_reg[b] + ACC_W'(p1_kern_reg)
                                * ACC_W'(rd_data_reg[b*QUANT_W +: QUANT_W]);
                end
            end
            if (sq_vld_reg) begin
                ssum_reg <= ssum_reg + 64'(sq_reg);
            end

            case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        if (!cmd_data.is_flush) begin
                            hist_valid_reg[head_reg] <= 1'b1;
                            head_reg        <= head_inc;
                            done_reg        <= 1'b0;
                            clear_after_reg <= 1'b0;
                            if (!cmd_data.smooth) begin
                                pending_reg <= '0;
                                for (int b = 0; b < CHROMA_BINS; b++) begin
                                    acc_reg[b] <= ACC_W'(cmd_data.quant[b*QUANT_W +: QUANT_W]);
                                end
                                ssum_reg  <= '0;
                                bidx_reg  <= '0;
                                state_reg <= ST_SQ;
                            end else if (pending_reg == DELAY_P) begin
                                // newest row sits at the old head
                                for (int b = 0; b < CHROMA_BINS; b++) begin
                                    acc_reg[b] <= '0;
                                end
                                ptr_reg   <= head_reg;
                                src_reg   <= '0;
                                ksum_reg  <= KI_W'(DELAY) + KI_W'(KHALF);
                                state_reg <= ST_ACC;
                            end else begin
                                pending_reg <= pending_reg + 1'b1;
                            end
                        end else begin
                            if (pending_reg == '0) begin
                                hist_valid_reg <= '0;
                                head_reg       <= '0;
                            end else begin
                                pending_reg     <= pend_dec;
                                done_reg        <= (pend_dec == '0);
                                clear_after_reg <= (pend_dec == '0);
                                for (int b = 0; b < CHROMA_BINS; b++) begin
                                    acc_reg[b] <= '0;
                                end
                                ptr_reg   <= head_dec;
                                src_reg   <= '0;
                                ksum_reg  <= KI_W'(pend_dec) + KI_W'(KHALF);
                                state_reg <= ST_ACC;
                            end
                        end
                    end
                end
                ST_ACC: begin
                    p1_use_reg  <= hist_valid_reg[ptr_reg] && src_in_kernel;
                    p1_kern_reg <= kern_tab[k_idx];
                    ptr_reg     <= ptr_dec;
                    if (src_reg == LAST_ROW) begin
                        state_reg <= ST_ACC_END;
                    end else begin
                        src_reg <= src_reg + 1'b1;
                    end
                end
                ST_ACC_END: begin
                    ssum_reg  <= '0;
                    bidx_reg  <= '0;
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    sq_reg     <= SQ_W'(acc_reg[bidx_reg]) * SQ_W'(acc_reg[bidx_reg]);
                    sq_vld_reg <= 1'b1;
                    if (bidx_reg == LAST_BIN) begin
                        state_reg <= ST_SQ_END;
                    end else begin
                        bidx_reg <= bidx_reg + 1'b1;
                    end
                end
                ST_SQ_END: begin
                    sh_reg    <= '0;
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    // scale by 4 until the top nibble is populated
                    if (ssum_reg == '0) begin
                        zero_reg  <= 1'b1;
                        bidx_reg  <= '0;
                        state_reg <= ST_DIV_INIT;
                    end else if (ssum_reg[63:60] == 4'd0) begin
                        ssum_reg <= ssum_reg << 2;
                        sh_reg   <= sh_reg + 1'b1;
                    end else begin
                        zero_reg  <= 1'b0;
                        root_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (ssum_reg >= sqrt_trial) begin
                        ssum_reg <= ssum_reg - sqrt_trial;
                        root_reg <= (root_reg >> 1) + sqrt_bit;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 5'd31) begin
                        bidx_reg  <= '0;
                        state_reg <= ST_DIV_INIT;
                    end
                end
                ST_DIV_INIT: begin
                    quo_reg <= '0;
                    if (zero_reg) begin
                        state_reg <= ST_OUT;
                    end else begin
                        rem_reg   <= DIV_W'({a_sh[32:0], 15'd0}) + DIV_W'(root_reg[63:1]);
                        dbit_reg  <= 5'(QUO_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rem_reg >= dvs) begin
                        rem_reg           <= rem_reg - dvs;
                        quo_reg[dbit_reg] <= 1'b1;
                    end
                    if (dbit_reg == '0) begin
                        state_reg <= ST_OUT;
                    end else begin
                        dbit_reg <= dbit_reg - 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_value_reg     <= (quo_reg > VALUE_MAX) ? VALUE_W'(VALUE_MAX)
                                                                 : quo_reg[VALUE_W-1:0];
                        m_bin_index_reg <= BIN_W'(bidx_reg);
                        m_last_reg      <= (bidx_reg == LAST_BIN);
                        m_clip_done_reg <= done_reg;
                        if (bidx_reg == LAST_BIN) begin
                            if (clear_after_reg) begin
                                hist_valid_reg <= '0;
                                head_reg       <= '0;
                            end
                            state_reg <= ST_IDLE;
                        end else begin
                            bidx_reg  <= bidx_reg + 1'b1;
                            state_reg <= ST_DIV_INIT;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= DELAY_P)
        else $error("pending frame count above smoothing delay");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_pop && cmd_data.is_flush && (pending_reg == '0))
        |=> (hist_valid_reg == '0) && (head_reg == '0))
        else $error("idle flush did not clear history");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ({1'b0, m_value_reg} <= VALUE_MAX))
        else $error("output value above full scale");

endmodule

`default_nettype wire
